/* hw/rtl/mlbl_pkg.sv */
package mlbl_pkg;

   localparam int DATA_W           = 16;
   localparam int CH_MAX           = 4;
   localparam int BOX_CHANNELS_DEF = 4;
   localparam int FIFO_DEPTH_DEF   = 2;
   localparam int DIST_W           = 18;
   localparam int BATCH_W          = 11;
   localparam int NB_W             = 27;
   localparam int NN_W             = 32;
   localparam int NNB_W            = 43;
   localparam int NUM_W            = 48;
   localparam int DEN_W            = 43;
   localparam int ACC_W            = 48;
   localparam int GRAD_W           = 32;
   localparam int LOSS_W           = 47;
   localparam int FRAC_SHIFT       = 16;
   localparam int NORM_SHIFT       = 24;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 16;

   localparam logic [DATA_W-1:0]  THRESH_RESET = DATA_W'(179);
   localparam logic [BATCH_W-1:0] BATCH_RESET  = BATCH_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_CONF_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_SIZE     = 1'b1;

   localparam logic [NUM_W-1:0] ACC_MAX  = {NUM_W{1'b1}};
   localparam logic [NUM_W-1:0] GRAD_MAX = {{(NUM_W-GRAD_W+1){1'b0}}, {(GRAD_W-1){1'b1}}};
   localparam logic [NUM_W-1:0] LOSS_MAX = {{(NUM_W-LOSS_W){1'b0}}, {LOSS_W{1'b1}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] conf_score;
      logic signed [DATA_W-1:0] pred_x0;
      logic signed [DATA_W-1:0] pred_y0;
      logic signed [DATA_W-1:0] pred_x1;
      logic signed [DATA_W-1:0] pred_y1;
      logic signed [DATA_W-1:0] true_x0;
      logic signed [DATA_W-1:0] true_y0;
      logic signed [DATA_W-1:0] true_x1;
      logic signed [DATA_W-1:0] true_y1;
      logic [DATA_W-1:0]        norm_value;
      logic                     batch_end;
   } req_item_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_conf;
      logic signed [GRAD_W-1:0] grad_norm;
      logic signed [GRAD_W-1:0] grad_pred_x0;
      logic signed [GRAD_W-1:0] grad_pred_y0;
      logic signed [GRAD_W-1:0] grad_pred_x1;
      logic signed [GRAD_W-1:0] grad_pred_y1;
      logic signed [GRAD_W-1:0] grad_true_x0;
      logic signed [GRAD_W-1:0] grad_true_y0;
      logic signed [GRAD_W-1:0] grad_true_x1;
      logic signed [GRAD_W-1:0] grad_true_y1;
      logic [LOSS_W-1:0]        loss_total;
      logic                     loss_valid;
   } rsp_item_type;

   typedef struct packed {
      logic [DIST_W-1:0] l1_dist;
      logic              mask;
      logic [CH_MAX-1:0] pos;
      logic [CH_MAX-1:0] en;
      logic [DATA_W-1:0] norm;
      logic              batch_end;
   } entry_type;

endpackage

/* hw/rtl/masked_l1_box_loss.sv */
// Channel   Direction  Handshake               Payload
// req_      in         req_push / req_full     req_item  (req_item_type)
// rsp_      out        rsp_pop / rsp_empty     rsp_item  (rsp_item_type)
// csr_      in         csr_valid / csr_ready   csr_index, csr_wdata
//
// The back end sends fewer quotients through the divider for an item whose confidence is
// below the threshold than for one that counts, and one more for the item that ends a
// batch; each quotient holds the single shared 48-step restoring divider, and one that is
// masked or has a zero divisor is settled without the divider.
// Reset is synchronous and clears both queues, the sequencer and the loss accumulator.
// Two-entry queues on either side of the arithmetic let input and output stall apart.
module masked_l1_box_loss
   import mlbl_pkg::*;
#(
   parameter int BOX_CHANNELS = BOX_CHANNELS_DEF,
   parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_item_type          req_item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_item_type          rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DATA_W-1:0]  thresh_ff;
   logic [BATCH_W-1:0] batch_ff;
   entry_type          front_entry, q_entry;
   logic               q_empty, q_pop;
   rsp_item_type       back_item;
   logic               out_full, out_push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         batch_ff  <= BATCH_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_CONF_THRESHOLD) begin
            thresh_ff <= csr_wdata[DATA_W-1:0];
         end else if (csr_index == CSR_BATCH_SIZE) begin
            batch_ff <= csr_wdata[BATCH_W-1:0];
         end
      end
   end

   mlbl_front #(
      .BOX_CHANNELS (BOX_CHANNELS)
   ) u_front (
      .req_item       (req_item),
      .conf_threshold (thresh_ff),
      .entry          (front_entry)
   );

   mlbl_fifo #(
      .DEPTH     (FIFO_DEPTH),
      .item_type (entry_type)
   ) u_in_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_entry),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (q_entry),
      .empty     (q_empty)
   );

   mlbl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_entry   (q_entry),
      .in_empty   (q_empty),
      .in_pop     (q_pop),
      .batch_size (batch_ff),
      .out_item   (back_item),
      .out_full   (out_full),
      .out_push   (out_push)
   );

   mlbl_fifo #(
      .DEPTH     (FIFO_DEPTH),
      .item_type (rsp_item_type)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_item (back_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_item),
      .empty     (rsp_empty)
   );

endmodule

/* hw/rtl/mlbl_fifo.sv */
module mlbl_fifo
   import mlbl_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH_DEF,
   parameter type item_type = entry_type
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/mlbl_front.sv */
module mlbl_front
   import mlbl_pkg::*;
#(
   parameter int BOX_CHANNELS = BOX_CHANNELS_DEF
) (
   input  req_item_type      req_item,
   input  logic [DATA_W-1:0] conf_threshold,
   output entry_type         entry
);

   logic signed [DATA_W-1:0] pred  [CH_MAX];
   logic signed [DATA_W-1:0] truth [CH_MAX];
   logic signed [DATA_W:0]   diff  [CH_MAX];
   logic [DATA_W:0]          mag   [CH_MAX];
   logic [DIST_W-1:0]        dist_sum;

   assign pred[0]  = req_item.pred_x0;
   assign pred[1]  = req_item.pred_y0;
   assign pred[2]  = req_item.pred_x1;
   assign pred[3]  = req_item.pred_y1;
   assign truth[0] = req_item.true_x0;
   assign truth[1] = req_item.true_y0;
   assign truth[2] = req_item.true_x1;
   assign truth[3] = req_item.true_y1;

   always_comb begin
      dist_sum = '0;
      for (int c = 0; c < CH_MAX; c++) begin
         diff[c] = $signed({pred[c][DATA_W-1], pred[c]})
                 - $signed({truth[c][DATA_W-1], truth[c]});
         mag[c]  = diff[c][DATA_W] ? unsigned'(-diff[c]) : unsigned'(diff[c]);
         entry.en[c]  = (c < BOX_CHANNELS);
         entry.pos[c] = (diff[c] > 0);
         if (c < BOX_CHANNELS) begin
            dist_sum = dist_sum + DIST_W'(mag[c]);
         end
      end
      entry.l1_dist   = dist_sum;
      entry.mask      = $signed({req_item.conf_score[DATA_W-1], req_item.conf_score})
                        >= $signed({1'b0, conf_threshold});
      entry.norm      = req_item.norm_value;
      entry.batch_end = req_item.batch_end;
   end

endmodule

/* hw/rtl/mlbl_div.sv */
module mlbl_div
   import mlbl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_diff;
   logic             fits;
   logic             take;

   assign take     = start && !busy_ff;
   assign rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign fits     = (rem_sh >= {1'b0, den_ff});
   assign done     = done_ff;
   assign quo      = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

/* hw/rtl/mlbl_back.sv */
module mlbl_back
   import mlbl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  entry_type          in_entry,
   input  logic               in_empty,
   output logic               in_pop,
   input  logic [BATCH_W-1:0] batch_size,
   output rsp_item_type       out_item,
   input  logic               out_full,
   output logic               out_push
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MUL1 = 9'b000000010,
      S_MUL2 = 9'b000000100,
      S_TERM = 9'b000001000,
      S_CONF = 9'b000010000,
      S_NORM = 9'b000100000,
      S_GP   = 9'b001000000,
      S_LOSS = 9'b010000000,
      S_PUSH = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic               issued_ff, issued_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   entry_type          ent_ff;
   logic [NB_W-1:0]    nb_ff;
   logic [NN_W-1:0]    nn_ff;
   logic [NNB_W-1:0]   nnb_ff;
   logic [GRAD_W-1:0]  conf_ff, norm_ff, gp_ff;
   logic [LOSS_W-1:0]  loss_ff;
   logic [BATCH_W-1:0] b_eff;
   logic [NUM_W-1:0]   num;
   logic [DEN_W-1:0]   den;
   logic [NUM_W-1:0]   vmax;
   logic [NUM_W-1:0]   val;
   logic [ACC_W:0]     acc_sum;
   logic               need, div_state, skip, advance;
   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_quo;
   logic [GRAD_W-1:0]  gpred [CH_MAX];

   assign b_eff = (batch_size == '0) ? BATCH_W'(1) : batch_size;

   mlbl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      num       = '0;
      den       = '0;
      vmax      = '0;
      need      = 1'b0;
      div_state = 1'b1;
      unique case (state_ff)
         S_TERM: begin
            num  = NUM_W'(ent_ff.l1_dist) << FRAC_SHIFT;
            den  = DEN_W'(ent_ff.norm);
            need = ent_ff.mask;
            vmax = ACC_MAX;
         end
         S_CONF: begin
            num  = NUM_W'(ent_ff.l1_dist) << FRAC_SHIFT;
            den  = DEN_W'(nb_ff);
            need = 1'b1;
            vmax = GRAD_MAX;
         end
         S_NORM: begin
            num  = NUM_W'(ent_ff.l1_dist) << NORM_SHIFT;
            den  = DEN_W'(nnb_ff);
            need = ent_ff.mask;
            vmax = GRAD_MAX;
         end
         S_GP: begin
            num  = NUM_W'(1) << NORM_SHIFT;
            den  = DEN_W'(nb_ff);
            need = ent_ff.mask;
            vmax = GRAD_MAX;
         end
         S_LOSS: begin
            num  = acc_ff;
            den  = DEN_W'(b_eff);
            need = ent_ff.batch_end;
            vmax = LOSS_MAX;
         end
         default: begin
            div_state = 1'b0;
         end
      endcase
   end

   always_comb begin
      skip      = !need || (den == '0);
      advance   = div_state && (skip || (issued_ff && div_done));
      div_start = div_state && !skip && !issued_ff;
      if (!need) begin
         val = '0;
      end else if (den == '0) begin
         val = (num != '0) ? vmax : '0;
      end else begin
         val = (div_quo > vmax) ? vmax : div_quo;
      end
      acc_sum = {1'b0, acc_ff} + {1'b0, val};
   end

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      acc_in    = acc_ff;
      in_pop    = 1'b0;
      out_push  = 1'b0;
      if (div_start) begin
         issued_in = 1'b1;
      end else if (advance) begin
         issued_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (!in_empty) begin
               in_pop   = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_TERM;
         S_TERM: begin
            if (advance) begin
               acc_in   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
               state_in = S_CONF;
            end
         end
         S_CONF: if (advance) state_in = S_NORM;
         S_NORM: if (advance) state_in = S_GP;
         S_GP:   if (advance) state_in = S_LOSS;
         S_LOSS: begin
            if (advance) begin
               if (ent_ff.batch_end) begin
                  acc_in = '0;
               end
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (in_pop) begin
         ent_ff <= in_entry;
      end
      if (state_ff == S_MUL1) begin
         nb_ff <= NB_W'(ent_ff.norm) * NB_W'(b_eff);
         nn_ff <= NN_W'(ent_ff.norm) * NN_W'(ent_ff.norm);
      end
      if (state_ff == S_MUL2) begin
         nnb_ff <= NNB_W'(nn_ff) * NNB_W'(b_eff);
      end
      if (advance) begin
         if (state_ff == S_CONF) conf_ff <= val[GRAD_W-1:0];
         if (state_ff == S_NORM) norm_ff <= val[GRAD_W-1:0];
         if (state_ff == S_GP)   gp_ff   <= val[GRAD_W-1:0];
         if (state_ff == S_LOSS) loss_ff <= val[LOSS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         acc_ff    <= acc_in;
      end
   end

   always_comb begin
      for (int c = 0; c < CH_MAX; c++) begin
         if (!ent_ff.en[c]) begin
            gpred[c] = '0;
         end else begin
            gpred[c] = ent_ff.pos[c] ? gp_ff : GRAD_W'(-gp_ff);
         end
      end
      out_item.grad_conf    = conf_ff;
      out_item.grad_norm    = GRAD_W'(-norm_ff);
      out_item.grad_pred_x0 = gpred[0];
      out_item.grad_pred_y0 = gpred[1];
      out_item.grad_pred_x1 = gpred[2];
      out_item.grad_pred_y1 = gpred[3];
      out_item.grad_true_x0 = GRAD_W'(-gpred[0]);
      out_item.grad_true_y0 = GRAD_W'(-gpred[1]);
      out_item.grad_true_x1 = GRAD_W'(-gpred[2]);
      out_item.grad_true_y1 = GRAD_W'(-gpred[3]);
      out_item.loss_total   = loss_ff;
      out_item.loss_valid   = ent_ff.batch_end;
   end

endmodule

/* hw/rtl/mlbl_checker.sv */
module mlbl_checker
   import mlbl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_push,
   input logic                  req_full,
   input req_item_type          req_item,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input rsp_item_type          rsp_item,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_item))
      else $error("waiting item changed or vanished");

   a_loss_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_item.loss_valid |-> rsp_item.loss_total == '0)
      else $error("loss reported outside batch end");

   a_grad_mirror: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> GRAD_W'(rsp_item.grad_true_x0 + rsp_item.grad_pred_x0) == '0)
      else $error("truth gradient does not mirror prediction gradient");

endmodule

bind masked_l1_box_loss mlbl_checker u_checker (.*);

/* tb/masked_l1_box_loss_tb.sv */
module masked_l1_box_loss_tb;
   import mlbl_pkg::*;

   localparam int ITEM_COUNT  = 1000;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [63:0] ACC_CAP   = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] LOSS_CAP  = 64'h7FFF_FFFF_FFFF;
   localparam logic [63:0] GRAD_CAP  = 64'h7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_item_type req_item = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_item_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count = 0;
   longint cycle_count = 0;
   bit stim_done = 1'b0;

   masked_l1_box_loss u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic logic [63:0] sat_div(input logic [63:0] num, input logic [63:0] den,
                                           input logic [63:0] cap);
      logic [63:0] q;
      if (den == 0) return (num != 0) ? cap : 64'd0;
      q = num / den;
      return (q > cap) ? cap : q;
   endfunction

   class loss_scoreboard;
      logic [15:0] threshold;
      logic [10:0] batch;
      logic [63:0] accumulator;
      rsp_item_type expected_q[$];

      function new();
         threshold = THRESH_RESET;
         batch = BATCH_RESET;
         accumulator = 0;
      endfunction

      function void note_item(req_item_type it);
         logic signed [16:0] diff[4];
         logic [63:0] l1_sum, n, b, gp, l;
         logic [31:0] g;
         bit counts;
         rsp_item_type r;
         counts = $signed({it.conf_score[15], it.conf_score}) >= $signed({1'b0, threshold});
         diff[0] = $signed(it.pred_x0) - $signed(it.true_x0);
         diff[1] = $signed(it.pred_y0) - $signed(it.true_y0);
         diff[2] = $signed(it.pred_x1) - $signed(it.true_x1);
         diff[3] = $signed(it.pred_y1) - $signed(it.true_y1);
         l1_sum = 0;
         foreach (diff[c]) l1_sum += diff[c] < 0 ? 64'(-diff[c]) : 64'(diff[c]);
         n = 64'(it.norm_value);
         b = (batch == 0) ? 64'd1 : 64'(batch);
         if (counts) accumulator += sat_div(l1_sum << 16, n, ACC_CAP);
         if (accumulator > ACC_CAP) accumulator = ACC_CAP;
         r = '0;
         r.grad_conf = 32'(sat_div(l1_sum << 16, n * b, GRAD_CAP));
         r.grad_norm = counts ? 32'(-sat_div(l1_sum << 24, n * n * b, GRAD_CAP)) : 32'd0;
         gp = counts ? sat_div(64'd1 << 24, n * b, GRAD_CAP) : 64'd0;
         g = gp[31:0];
         r.grad_pred_x0 = diff[0] > 0 ? g : -g;
         r.grad_pred_y0 = diff[1] > 0 ? g : -g;
         r.grad_pred_x1 = diff[2] > 0 ? g : -g;
         r.grad_pred_y1 = diff[3] > 0 ? g : -g;
         r.grad_true_x0 = -r.grad_pred_x0;
         r.grad_true_y0 = -r.grad_pred_y0;
         r.grad_true_x1 = -r.grad_pred_x1;
         r.grad_true_y1 = -r.grad_pred_y1;
         if (it.batch_end) begin
            l = accumulator / b;
            r.loss_total = 47'((l > LOSS_CAP) ? LOSS_CAP : l);
            r.loss_valid = 1'b1;
            accumulator = 0;
         end
         expected_q.push_back(r);
      endfunction

      task check_result(rsp_item_type got);
         rsp_item_type w;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected item", got.loss_total, 0);
            return;
         end
         w = expected_q.pop_front();
         if (got.grad_conf !== w.grad_conf) report_mismatch("grad_conf", got.grad_conf, w.grad_conf);
         if (got.grad_norm !== w.grad_norm) report_mismatch("grad_norm", got.grad_norm, w.grad_norm);
         if (got.grad_pred_x0 !== w.grad_pred_x0)
            report_mismatch("grad_pred_x0", got.grad_pred_x0, w.grad_pred_x0);
         if (got.grad_pred_y0 !== w.grad_pred_y0)
            report_mismatch("grad_pred_y0", got.grad_pred_y0, w.grad_pred_y0);
         if (got.grad_pred_x1 !== w.grad_pred_x1)
            report_mismatch("grad_pred_x1", got.grad_pred_x1, w.grad_pred_x1);
         if (got.grad_pred_y1 !== w.grad_pred_y1)
            report_mismatch("grad_pred_y1", got.grad_pred_y1, w.grad_pred_y1);
         if (got.grad_true_x0 !== w.grad_true_x0)
            report_mismatch("grad_true_x0", got.grad_true_x0, w.grad_true_x0);
         if (got.grad_true_y0 !== w.grad_true_y0)
            report_mismatch("grad_true_y0", got.grad_true_y0, w.grad_true_y0);
         if (got.grad_true_x1 !== w.grad_true_x1)
            report_mismatch("grad_true_x1", got.grad_true_x1, w.grad_true_x1);
         if (got.grad_true_y1 !== w.grad_true_y1)
            report_mismatch("grad_true_y1", got.grad_true_y1, w.grad_true_y1);
         if (got.loss_total !== w.loss_total)
            report_mismatch("loss_total", got.loss_total, w.loss_total);
         if (got.loss_valid !== w.loss_valid)
            report_mismatch("loss_valid", got.loss_valid, w.loss_valid);
      endtask
   endclass

   loss_scoreboard board = new();

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_item(input req_item_type it);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      board.note_item(it);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_CONF_THRESHOLD) board.threshold = value;
      else board.batch = value[10:0];
      @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic req_item_type random_item(input bit end_flag);
      req_item_type it;
      it.conf_score = rand_value();
      it.pred_x0 = rand_value();
      it.pred_y0 = rand_value();
      it.pred_x1 = rand_value();
      it.pred_y1 = rand_value();
      it.true_x0 = rand_value();
      it.true_y0 = rand_value();
      it.true_x1 = rand_value();
      it.true_y1 = rand_value();
      case ($urandom_range(0, 7))
         0: it.norm_value = 16'h0000;
         1: it.norm_value = 16'hFFFF;
         2: it.norm_value = 16'h0100;
         default: it.norm_value = 16'($urandom);
      endcase
      it.batch_end = end_flag;
      return it;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) board.check_result(rsp_item);
         rsp_pop <= (gap_length() == 0) || ($urandom_range(0, 3) != 0 &&
                    $urandom_range(0, 9) != 0);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      logic [15:0] thresholds[5] = '{16'd0, 16'd179, 16'hFFFF, 16'h7FFF, 16'h8000};
      logic [15:0] batches[5] = '{16'd1, 16'd1024, 16'd3, 16'd0, 16'd64};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      it = '0;
      it.conf_score = 16'h7FFF;
      it.norm_value = 16'h0100;
      push_item(it);
      it.pred_x0 = 16'h7FFF; it.true_x0 = 16'h8000;
      it.pred_y0 = 16'h8000; it.true_y0 = 16'h7FFF;
      it.pred_x1 = 16'h7FFF; it.true_x1 = 16'h8000;
      it.pred_y1 = 16'h8000; it.true_y1 = 16'h7FFF;
      push_item(it);
      it.norm_value = 16'h0000;
      push_item(it);
      it.norm_value = 16'h0001;
      push_item(it);
      it.norm_value = 16'hFFFF;
      it.conf_score = 16'd178;
      push_item(it);
      it.conf_score = 16'd179;
      it.batch_end = 1'b1;
      push_item(it);
      it.conf_score = 16'h8000;
      push_item(it);
      it = '0;
      it.conf_score = 16'd200;
      it.batch_end = 1'b1;
      push_item(it);
      for (int k = 0; k < 8; k++) push_item(random_item($urandom_range(0, 1)));
      drain();
      for (int phase = 0; phase < 5; phase++) begin
         write_register(CSR_CONF_THRESHOLD, thresholds[phase]);
         write_register(CSR_BATCH_SIZE, batches[phase]);
         for (int k = 0; k < ITEM_COUNT / 5; k++) begin
            push_item(random_item($urandom_range(0, 7) == 0));
            if (phase == 2 && k == 100) drain();
         end
         drain();
      end
      if (board.expected_q.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/mlbl_pkg.sv
hw/rtl/mlbl_fifo.sv
hw/rtl/mlbl_front.sv
hw/rtl/mlbl_div.sv
hw/rtl/mlbl_back.sv
hw/rtl/masked_l1_box_loss.sv
hw/rtl/mlbl_checker.sv
tb/masked_l1_box_loss_tb.sv
